[src/dldq_pkg.sv]
// Shared types, request codes and sizing constants for the doubly linked deque manager.
// Used by dldq_ctrl, dldq_dpath and the top level; depends on nothing.
package dldq_pkg;

    localparam int ID_W = 8;
    localparam int COUNT_W = 9;
    localparam int LINK_W = 8;
    localparam int SLOT_LIMIT = 256;
    localparam int NODE_SLOTS_DEFAULT = 256;

    localparam logic [1:0] REQ_ADD_HEAD = 2'd0;
    localparam logic [1:0] REQ_ADD_TAIL = 2'd1;
    localparam logic [1:0] REQ_REMOVE_HEAD = 2'd2;
    localparam logic [1:0] REQ_REMOVE_TAIL = 2'd3;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] node_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]    removed_id;
        logic               removed_valid;
        logic               add_refused;
        logic [COUNT_W-1:0] node_count;
        logic               list_empty;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic finish;
        logic clear;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

[src/dldq_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package dependencies.
module dldq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/dldq_ctrl.sv]
// Request sequencer for the deque manager: mark clearing, accept, update and result hand-off.
// Depends on dldq_pkg for the command and status structs.
module dldq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  dldq_pkg::status_t status,
    output dldq_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_LOOK = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    // Take a transaction only when idle and the result register is free or draining
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    assign cmd.accept = accept;
    assign cmd.finish = (state_reg == ST_LOOK);
    assign cmd.clear = (state_reg == ST_CLEAR);

    // Advance the sequencer and track the pending result
    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_IDLE;
                m_valid_next = 1'b1;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The update state is always followed in the next cycle by idle with a result pending
    a_link_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |=> (state_reg == ST_IDLE) && m_valid_reg)
        else $error("update cycle did not complete with a result");

    // No new transaction outside the idle state
    a_no_accept_in_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("accepted outside idle");

    // No result is offered while the marks are being cleared
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_valid_reg)
        else $error("result offered during mark clearing");

endmodule

[src/dldq_dpath.sv]
// Datapath of the deque manager: head/tail/count registers, linked-mark RAM,
// next and prev link RAMs and the result register. Depends on dldq_pkg and dldq_ram.
module dldq_dpath #(
    parameter int NODE_SLOTS = dldq_pkg::NODE_SLOTS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dldq_pkg::req_t    s_data,
    input  dldq_pkg::cmd_t    cmd,
    output dldq_pkg::status_t status,
    output dldq_pkg::rsp_t    m_data
);

    // Only slots reachable by an 8-bit node number are ever stored
    localparam int SLOT_DEPTH = (NODE_SLOTS < dldq_pkg::SLOT_LIMIT) ?
                                NODE_SLOTS : dldq_pkg::SLOT_LIMIT;
    localparam int ADDR_W = $clog2(SLOT_DEPTH);
    localparam int ID_W = dldq_pkg::ID_W;
    localparam int COUNT_W = dldq_pkg::COUNT_W;
    localparam int LINK_W = dldq_pkg::LINK_W;

    logic [ID_W-1:0]    head_reg, head_next;
    logic [ID_W-1:0]    tail_reg, tail_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0]  clear_addr_reg, clear_addr_next;
    dldq_pkg::req_t     req_reg;
    dldq_pkg::rsp_t     rsp_reg, rsp_next;
    logic               rsp_load;

    logic              next_we, prev_we, mark_we;
    logic [ADDR_W-1:0] next_waddr, prev_waddr, mark_waddr;
    logic [ADDR_W-1:0] link_raddr, mark_raddr;
    logic [LINK_W-1:0] next_wdata, prev_wdata;
    logic [LINK_W-1:0] next_rdata, prev_rdata;
    logic [0:0]        mark_wdata, mark_rdata;

    logic              id_in_pool;
    logic              refused;
    logic              list_empty_now;
    logic              tail_op;
    logic [ADDR_W-1:0] id_a, head_a, tail_a;
    logic [ID_W-1:0]   r_id;
    logic [ID_W-1:0]   new_end;

    assign id_a = req_reg.node_id[ADDR_W-1:0];
    assign head_a = head_reg[ADDR_W-1:0];
    assign tail_a = tail_reg[ADDR_W-1:0];
    assign id_in_pool = (32'(req_reg.node_id) < 32'(SLOT_DEPTH));
    assign refused = !id_in_pool || mark_rdata[0];
    assign list_empty_now = (count_reg == '0);
    assign tail_op = (req_reg.req_type == dldq_pkg::REQ_REMOVE_TAIL);

    // Fetch the mark of the named node and the link behind the chosen end on acceptance
    assign mark_raddr = s_data.node_id[ADDR_W-1:0];
    assign link_raddr = (s_data.req_type == dldq_pkg::REQ_REMOVE_TAIL) ? tail_a : head_a;

    assign r_id = tail_op ? tail_reg : head_reg;
    assign new_end = tail_op ? prev_rdata : next_rdata;

    assign status.clear_last = (clear_addr_reg == ADDR_W'(SLOT_DEPTH - 1));

    // Clear the marks after reset, then apply each request in its update cycle
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        clear_addr_next = clear_addr_reg;
        next_we = 1'b0;
        next_waddr = id_a;
        next_wdata = '0;
        prev_we = 1'b0;
        prev_waddr = id_a;
        prev_wdata = '0;
        mark_we = 1'b0;
        mark_waddr = id_a;
        mark_wdata = 1'b0;
        rsp_next = '0;
        rsp_load = 1'b0;

        if (cmd.clear) begin
            mark_we = 1'b1;
            mark_waddr = clear_addr_reg;
            clear_addr_next = clear_addr_reg + ADDR_W'(1);
        end else if (cmd.finish) begin
            rsp_load = 1'b1;
            unique case (req_reg.req_type) inside
                dldq_pkg::REQ_ADD_HEAD, dldq_pkg::REQ_ADD_TAIL: begin
                    rsp_next.add_refused = refused;
                    if (!refused) begin
                        mark_we = 1'b1;
                        mark_waddr = id_a;
                        mark_wdata = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                        if (list_empty_now) begin
                            head_next = req_reg.node_id;
                            tail_next = req_reg.node_id;
                        end else if (req_reg.req_type == dldq_pkg::REQ_ADD_HEAD) begin
                            // Link new node in front of the old head
                            next_we = 1'b1;
                            next_waddr = id_a;
                            next_wdata = head_reg;
                            prev_we = 1'b1;
                            prev_waddr = head_a;
                            prev_wdata = req_reg.node_id;
                            head_next = req_reg.node_id;
                        end else begin
                            // Link new node behind the old tail
                            prev_we = 1'b1;
                            prev_waddr = id_a;
                            prev_wdata = tail_reg;
                            next_we = 1'b1;
                            next_waddr = tail_a;
                            next_wdata = req_reg.node_id;
                            tail_next = req_reg.node_id;
                        end
                    end
                end
                default: begin
                    // Removals: drop the only node, or detach the end and terminate the new end
                    if (count_reg == COUNT_W'(1)) begin
                        rsp_next.removed_id = head_reg;
                        rsp_next.removed_valid = 1'b1;
                        mark_we = 1'b1;
                        mark_waddr = head_a;
                        head_next = '0;
                        tail_next = '0;
                        count_next = '0;
                    end else if (!list_empty_now) begin
                        rsp_next.removed_id = r_id;
                        rsp_next.removed_valid = 1'b1;
                        mark_we = 1'b1;
                        mark_waddr = r_id[ADDR_W-1:0];
                        count_next = count_reg - COUNT_W'(1);
                        if (tail_op) begin
                            tail_next = new_end;
                            next_we = 1'b1;
                            next_waddr = new_end[ADDR_W-1:0];
                        end else begin
                            head_next = new_end;
                            prev_we = 1'b1;
                            prev_waddr = new_end[ADDR_W-1:0];
                        end
                    end
                end
            endcase
        end

        rsp_next.node_count = count_next;
        rsp_next.list_empty = (count_next == '0);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            clear_addr_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    // Hold the accepted request and the result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= s_data;
        end
        if (rsp_load) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_data = rsp_reg;

    dldq_ram #(
        .WIDTH(LINK_W),
        .DEPTH(SLOT_DEPTH)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (link_raddr),
        .rdata (next_rdata)
    );

    dldq_ram #(
        .WIDTH(LINK_W),
        .DEPTH(SLOT_DEPTH)
    ) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (link_raddr),
        .rdata (prev_rdata)
    );

    dldq_ram #(
        .WIDTH(1),
        .DEPTH(SLOT_DEPTH)
    ) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    // The count never exceeds the pool
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(SLOT_DEPTH))
        else $error("node count beyond pool size");

    // An empty list keeps both ends at zero
    a_empty_ends_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty list with non-zero ends");

    // A single-node list has one node at both ends
    a_single_ends_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == COUNT_W'(1)) |-> (head_reg == tail_reg))
        else $error("single-node list with differing ends");

    // No request activity while the marks are being cleared
    a_clear_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !cmd.accept && !cmd.finish)
        else $error("request activity during mark clearing");

endmodule

[src/doubly_linked_deque_manager.sv]
// Top level of the doubly linked deque manager.
// Depends on dldq_pkg, dldq_ctrl and dldq_dpath (which uses dldq_ram).
//
// Usage:
//   s_valid/s_ready/s_data carry one request transaction: req_type (add at
//   head, add at tail, remove head, remove tail) and node_id for adds.
//   m_valid/m_ready/m_data return exactly one result per request: removed
//   node, refused-add flag, node count and empty flag after the request.
// Request flow:
//   The linked-mark and link RAMs are read with registered reads at the
//   accepting edge; the update and the result load follow at the next
//   edge, where m_valid rises. A new request is taken in the cycle a result
//   is consumed, and no new request is taken while one is in flight.
// Reset:
//   aresetn (synchronous, active low) clears head, tail and count, then a
//   pass over every slot (256 by default) clears the linked marks with
//   s_ready low. Link RAMs are not cleared; entries are written before read.
// Stall:
//   While m_valid is high and m_ready low the result holds and s_ready
//   stays low; nothing is lost or repeated.
module doubly_linked_deque_manager #(
    parameter int NODE_SLOTS = dldq_pkg::NODE_SLOTS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dldq_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dldq_pkg::rsp_t m_data
);

    dldq_pkg::cmd_t    cmd;
    dldq_pkg::status_t status;

    dldq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dldq_dpath #(
        .NODE_SLOTS(NODE_SLOTS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule
